[rtl/core/ppts_pkg.sv]
// Shared types, constants and helpers for the perspective projection core.
`default_nettype none
package ppts_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned HALF_W     = CFG_W - 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DIVIDEND_W = DATA_W + FRAC_W;
  localparam int unsigned DIV_SPS    = 4;
  localparam int unsigned DIV_STAGES = DIVIDEND_W / DIV_SPS;
  localparam int unsigned SUM_W      = 50;

  localparam logic signed [DATA_W-1:0] W_MIN = 32'sd6554;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd1080;

  typedef enum logic {
    OP_PROJECT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic vis;
  } ppts_tag_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFFFFFF);
    lo = -SUM_W'(64'sh80000000);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/ppts_clip.sv]
// Matrix store and clip-space transform: multiply stage, then floor, sum and saturate.
`default_nettype none
module ppts_clip (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            adv,
  input  ppts_pkg::ppts_tag_t            tag_i,
  input  wire                            load_en,
  input  wire  [3:0]                     load_idx,
  input  wire  signed [31:0]             load_val,
  input  wire  signed [31:0]             pos_x,
  input  wire  signed [31:0]             pos_y,
  input  wire  signed [31:0]             pos_z,
  output ppts_pkg::ppts_tag_t            tag_o,
  output logic signed [31:0]             clip_x,
  output logic signed [31:0]             clip_y,
  output logic signed [31:0]             clip_w
);
  import ppts_pkg::*;

  logic signed [DATA_W-1:0] mat_r [16];
  logic signed [DATA_W-1:0] pos [3];
  logic signed [63:0]       prod_r [3][3];
  logic signed [DATA_W-1:0] off_r [3];
  logic signed [DATA_W-1:0] clip_r [3];
  logic signed [DATA_W-1:0] clip_nxt [3];
  ppts_tag_t                tag1_r;
  ppts_tag_t                tag2_r;

  function automatic logic [3:0] mat_idx(input int r, input int c);
    logic [1:0] row;
    row = (r == 2) ? 2'd3 : 2'(r);
    return {row, 2'(c)};
  endfunction

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else if (load_en) begin
      mat_r[load_idx] <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (adv) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= pos[c] * mat_r[mat_idx(r, c)];
        end
        off_r[r] <= mat_r[mat_idx(r, 3)];
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = SUM_W'(off_r[r]);
      for (int c = 0; c < 3; c++) begin
        acc = acc + SUM_W'($signed(prod_r[r][c][63:FRAC_W]));
      end
      clip_nxt[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) clip_r[r] <= clip_nxt[r];
    end
  end

  assign tag_o  = tag2_r;
  assign clip_x = clip_r[0];
  assign clip_y = clip_r[1];
  assign clip_w = clip_r[2];

endmodule
`default_nettype wire

[rtl/core/ppts_div.sv]
// Pipelined restoring divider for both NDC lanes, four quotient bits per stage.
`default_nettype none
module ppts_div (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     adv,
  input  ppts_pkg::ppts_tag_t                     tag_i,
  input  wire  signed [31:0]                      clip_x,
  input  wire  signed [31:0]                      clip_y,
  input  wire  signed [31:0]                      clip_w,
  output ppts_pkg::ppts_tag_t                     tag_o,
  output logic [ppts_pkg::DIVIDEND_W-1:0]         quot_x,
  output logic [ppts_pkg::DIVIDEND_W-1:0]         quot_y,
  output logic [1:0]                              neg
);
  import ppts_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]     rem;
    logic [DIVIDEND_W-1:0] num;
  } dstate_t;

  ppts_tag_t         tag_r [DIV_STAGES+1];
  logic [1:0]        neg_r [DIV_STAGES+1];
  dstate_t           st_r  [DIV_STAGES+1][2];
  logic [DATA_W-1:0] den_r [DIV_STAGES];
  logic [DATA_W-1:0] mag_x;
  logic [DATA_W-1:0] mag_y;
  ppts_tag_t         tag_nxt;

  function automatic dstate_t div_iter(input dstate_t s, input logic [DATA_W-1:0] d);
    logic [DATA_W:0] t;
    dstate_t o;
    o = s;
    for (int k = 0; k < DIV_SPS; k++) begin
      t = {o.rem, o.num[DIVIDEND_W-1]};
      if (t >= {1'b0, d}) begin
        o.rem = DATA_W'(t - {1'b0, d});
        o.num = {o.num[DIVIDEND_W-2:0], 1'b1};
      end else begin
        o.rem = t[DATA_W-1:0];
        o.num = {o.num[DIVIDEND_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  assign mag_x = clip_x[DATA_W-1] ? DATA_W'(-clip_x) : DATA_W'(clip_x);
  assign mag_y = clip_y[DATA_W-1] ? DATA_W'(-clip_y) : DATA_W'(clip_y);

  always_comb begin
    tag_nxt       = tag_i;
    tag_nxt.vis   = clip_w >= W_MIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (adv) begin
      tag_r[0] <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r[0]  <= {clip_y[DATA_W-1], clip_x[DATA_W-1]};
      den_r[0]  <= clip_w;
      st_r[0][0] <= '{rem: '0, num: {mag_x, FRAC_W'(0)}};
      st_r[0][1] <= '{rem: '0, num: {mag_y, FRAC_W'(0)}};
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s] <= '0;
      end else if (adv) begin
        tag_r[s] <= tag_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        neg_r[s]   <= neg_r[s-1];
        st_r[s][0] <= div_iter(st_r[s-1][0], den_r[s-1]);
        st_r[s][1] <= div_iter(st_r[s-1][1], den_r[s-1]);
      end
    end

    if (s < DIV_STAGES) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign tag_o  = tag_r[DIV_STAGES];
  assign neg    = neg_r[DIV_STAGES];
  assign quot_x = st_r[DIV_STAGES][0].num;
  assign quot_y = st_r[DIV_STAGES][1].num;

endmodule
`default_nettype wire

[rtl/core/ppts_screen.sv]
// Viewport mapping: NDC saturation, half-size multiply, offset and output register.
`default_nettype none
module ppts_screen (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               adv,
  input  ppts_pkg::ppts_tag_t               tag_i,
  input  wire  [ppts_pkg::DIVIDEND_W-1:0]   quot_x,
  input  wire  [ppts_pkg::DIVIDEND_W-1:0]   quot_y,
  input  wire  [1:0]                        neg,
  input  wire  [ppts_pkg::HALF_W-1:0]       half_w,
  input  wire  [ppts_pkg::HALF_W-1:0]       half_h,
  output ppts_pkg::ppts_tag_t               tag_o,
  output logic signed [31:0]                screen_x,
  output logic signed [31:0]                screen_y
);
  import ppts_pkg::*;

  localparam int unsigned PROD_W = HALF_W + 1 + DATA_W;

  ppts_tag_t                tag1_r;
  ppts_tag_t                tag2_r;
  ppts_tag_t                tag3_r;
  logic signed [DATA_W-1:0] ndc_x_r;
  logic signed [DATA_W-1:0] ndc_y_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [DATA_W-1:0] sx_r;
  logic signed [DATA_W-1:0] sy_r;
  logic signed [SUM_W-1:0]  off_w;
  logic signed [SUM_W-1:0]  off_h;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;

  function automatic logic signed [DATA_W-1:0] ndc_sat(input logic [DIVIDEND_W-1:0] q,
                                                      input logic n);
    if (!n) begin
      if (q > DIVIDEND_W'(64'h7FFFFFFF)) return 32'sh7FFFFFFF;
      return q[DATA_W-1:0];
    end
    if (q > DIVIDEND_W'(64'h80000000)) return 32'sh80000000;
    return DATA_W'(-q[DATA_W-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (adv) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign off_w = $signed({(SUM_W-HALF_W-FRAC_W)'(0), half_w, FRAC_W'(0)});
  assign off_h = $signed({(SUM_W-HALF_W-FRAC_W)'(0), half_h, FRAC_W'(0)});
  assign sum_x = SUM_W'(prod_x_r) + off_w;
  assign sum_y = off_h - SUM_W'(prod_y_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ndc_x_r  <= ndc_sat(quot_x, neg[0]);
      ndc_y_r  <= ndc_sat(quot_y, neg[1]);
      prod_x_r <= $signed({1'b0, half_w}) * ndc_x_r;
      prod_y_r <= $signed({1'b0, half_h}) * ndc_y_r;
      sx_r     <= tag2_r.vis ? sat32(sum_x) : '0;
      sy_r     <= tag2_r.vis ? sat32(sum_y) : '0;
    end
  end

  assign tag_o    = tag3_r;
  assign screen_x = sx_r;
  assign screen_y = sy_r;

endmodule
`default_nettype wire

[rtl/core/perspective_project_to_screen_core.sv]
// Top level of the world-to-screen perspective projection core.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid / in_stall, in_* fields   | in
//   result  | out_valid / out_stall, out_*       | out
//   config  | cfg_we, cfg_index, cfg_wdata       | in
//
// One request per cycle while no valid result is stalled; a projection passes
// through 2 transform stages, 13 divider stages and 3 viewport stages.
// Load requests write the matrix at acceptance and give no result.
// Reset clears the matrix and the valid bits and restores 1920 x 1080.
// A stalled valid result freezes every stage, so in_stall is out_stall while out_valid is high.
`default_nettype none
module perspective_project_to_screen_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_operation,
  input  wire  [3:0]         in_coef_index,
  input  wire  signed [31:0] in_coef_value,
  input  wire  signed [31:0] in_pos_x,
  input  wire  signed [31:0] in_pos_y,
  input  wire  signed [31:0] in_pos_z,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_visible,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  input  wire                cfg_we,
  input  wire  [0:0]         cfg_index,
  input  wire  [13:0]        cfg_wdata
);
  import ppts_pkg::*;

  logic                     adv;
  logic                     acc;
  logic [CFG_W-1:0]         scr_w_r;
  logic [CFG_W-1:0]         scr_h_r;
  ppts_tag_t                tag_in;
  ppts_tag_t                tag_clip;
  ppts_tag_t                tag_div;
  ppts_tag_t                tag_out;
  logic signed [DATA_W-1:0] clip_x;
  logic signed [DATA_W-1:0] clip_y;
  logic signed [DATA_W-1:0] clip_w;
  logic [DIVIDEND_W-1:0]    quot_x;
  logic [DIVIDEND_W-1:0]    quot_y;
  logic [1:0]               neg;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  assign tag_in.valid = acc && (op_t'(in_operation) == OP_PROJECT);
  assign tag_in.vis   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= WIDTH_RST;
      scr_h_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppts_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .tag_i    (tag_in),
    .load_en  (acc && (op_t'(in_operation) == OP_LOAD)),
    .load_idx (in_coef_index),
    .load_val (in_coef_value),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .tag_o    (tag_clip),
    .clip_x   (clip_x),
    .clip_y   (clip_y),
    .clip_w   (clip_w)
  );

  ppts_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_i  (tag_clip),
    .clip_x (clip_x),
    .clip_y (clip_y),
    .clip_w (clip_w),
    .tag_o  (tag_div),
    .quot_x (quot_x),
    .quot_y (quot_y),
    .neg    (neg)
  );

  ppts_screen u_screen (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .tag_i    (tag_div),
    .quot_x   (quot_x),
    .quot_y   (quot_y),
    .neg      (neg),
    .half_w   (scr_w_r[CFG_W-1:1]),
    .half_h   (scr_h_r[CFG_W-1:1]),
    .tag_o    (tag_out),
    .screen_x (out_screen_x),
    .screen_y (out_screen_y)
  );

  assign out_valid   = tag_out.valid;
  assign out_visible = tag_out.vis;

endmodule
`default_nettype wire
